/* rtl/core/lkv_pkg.sv */
package lkv_pkg;

	localparam int ENTRIES    = 64;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 32;
	localparam int CAP_BITS   = 7;
	localparam int IDX_W      = $clog2(ENTRIES);
	localparam int CNT_W      = $clog2(ENTRIES + 1);

	typedef enum logic {
		ACT_GET = 1'b0,
		ACT_PUT = 1'b1
	} action_t;

	typedef struct packed {
		action_t                 action;
		logic [KEY_BITS-1:0]     lookup_key;
		logic [VALUE_BITS-1:0]   store_value;
	} req_t;

	typedef struct packed {
		logic                    hit;
		logic [VALUE_BITS-1:0]   read_value;
	} rsp_t;

	typedef struct packed {
		logic                    valid;
		logic [KEY_BITS-1:0]     key;
		logic [VALUE_BITS-1:0]   value;
	} entry_t;

	typedef struct packed {
		logic                    shift;
		logic [KEY_BITS-1:0]     key;
	} cell_cmd_t;

endpackage

/* rtl/core/lkv_cell.sv */
module lkv_cell
	import lkv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  entry_t    prev_entry,
	output entry_t    entry,
	output logic      match
);

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;

	// A cell takes its neighbor's entry when the row shifts through it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= prev_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			key_q   <= prev_entry.key;
			value_q <= prev_entry.value;
		end
	end

	assign match = valid_q && (key_q == cmd.key);

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.value = value_q;

endmodule

/* rtl/core/lru_key_value_cache_unit.sv */
// Fully associative key-value cache with least-recently-used replacement.
// Requests arrive on in_valid/in_stall/in_data. A get returns one response on
// out_valid/out_stall/out_data with a hit flag and the stored value, or zero
// on a miss. A put updates or inserts the key and returns no response.
// Entries sit in a row of cells ordered by recency, the most recent at the
// head; every hit or put moves the touched or new entry to the head and shifts
// the entries in front of it down by one cell.
// A request is registered when accepted and resolved when it commits: every
// cell compares its key and the row shifts. in_stall stays high meanwhile, so
// no new request is taken while one is in progress. A get's response is
// registered as it commits. While a response waits under out_stall, a following
// get holds in the block and in_stall stays high; puts still complete.
// cfg_we writes the capacity register; zero acts as one and values above the
// cell count act as the full row. Lowering it evicts one entry per new key.
// Reset empties the cache, sets the capacity to the full row and drops any
// pending request or response.
module lru_key_value_cache_unit
	import lkv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  req_t                in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rsp_t                out_data,
	input  logic                cfg_we,
	input  logic [CAP_BITS-1:0] cfg_wdata
);

	logic                  busy_q;
	req_t                  req_q;
	logic [CAP_BITS-1:0]   cap_q;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	rsp_t                  out_q;

	entry_t                cells [ENTRIES];
	logic [ENTRIES-1:0]    match;
	logic                  hit;
	logic [IDX_W-1:0]      hit_idx;
	logic [VALUE_BITS-1:0] hit_value;
	logic [CNT_W-1:0]      limit;
	logic                  evict;
	logic [IDX_W-1:0]      pos;
	logic                  is_get;
	logic                  commit;
	entry_t                new_entry;

	assign in_stall  = busy_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		hit_idx   = '0;
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_idx   = hit_idx | IDX_W'(i);
				hit_value = hit_value | cells[i].value;
			end
		end
	end

	assign hit = |match;

	always_comb begin
		if (cap_q == '0) begin
			limit = CNT_W'(1);
		end else if (CNT_W'(cap_q) > CNT_W'(ENTRIES)) begin
			limit = CNT_W'(ENTRIES);
		end else begin
			limit = CNT_W'(cap_q);
		end
	end

	assign evict  = count_q >= limit;
	assign is_get = req_q.action == ACT_GET;
	assign commit = busy_q && !(is_get && out_valid_q && out_stall);

	// The last cell that moves: the hit entry, the least recent one when
	// evicting, or the first empty cell otherwise.
	always_comb begin
		if (hit) begin
			pos = hit_idx;
		end else if (evict) begin
			pos = IDX_W'(count_q - CNT_W'(1));
		end else begin
			pos = IDX_W'(count_q);
		end
	end

	assign new_entry.valid = 1'b1;
	assign new_entry.key   = req_q.lookup_key;
	assign new_entry.value = is_get ? hit_value : req_q.store_value;

	// A get that misses leaves the row untouched.
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		cell_cmd_t cmd;
		entry_t    prev;

		assign cmd.shift = commit && (hit || !is_get) && (IDX_W'(g) <= pos);
		assign cmd.key   = req_q.lookup_key;

		if (g == 0) begin : g_head
			assign prev = new_entry;
		end else begin : g_tail
			assign prev = cells[g-1];
		end

		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_entry (prev),
			.entry      (cells[g]),
			.match      (match[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cap_q       <= CAP_BITS'(ENTRIES);
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (in_valid && !in_stall) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit && !is_get && !hit && !evict) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (commit && is_get) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_q <= in_data;
		end
		if (commit && is_get) begin
			out_q.hit        <= hit;
			out_q.read_value <= hit_value;
		end
	end

endmodule

/* rtl/core/lkv_checker.sv */
module lkv_checker
	import lkv_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input req_t                in_data,
	input logic                out_valid,
	input logic                out_stall,
	input rsp_t                out_data,
	input logic                cfg_we,
	input logic [CAP_BITS-1:0] cfg_wdata
);

	logic in_acc;
	logic put_acc;

	assign in_acc  = in_valid && !in_stall;
	assign put_acc = in_acc && (in_data.action == ACT_PUT);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("request taken while the previous one is in progress");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.hit |-> out_data.read_value == '0)
		else $error("miss response carries a nonzero value");

	a_put_silent: assert property (@(posedge clk) disable iff (!arst_n)
		put_acc |-> ##2 !$rose(out_valid))
		else $error("put produced a response");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (.*);
